[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CHK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[rtl/core/egbr_pkg.sv]
// ----------------------------------------------------------------------------
// egbr_pkg
// Types and constants of the Exp-Golomb bit reader.
// ----------------------------------------------------------------------------
package egbr_pkg;

    localparam int BYTE_W    = 8;
    localparam int NBITS_W   = 6;
    localparam int VALUE_W   = 32;
    localparam int MAX_FIELD = 32;
    localparam int MAX_ZEROS = 32;
    localparam int AVAIL_W   = 4;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_FIXED = 2'd1,
        REQ_UE    = 2'd2,
        REQ_SE    = 2'd3
    } egbr_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIXED,
        ST_PREFIX,
        ST_SUFFIX,
        ST_DEC,
        ST_MAP,
        ST_RESULT
    } egbr_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } egbr_q_status_t;

    typedef struct packed {
        logic valid;
        logic bit_val;
        logic underrun;
    } egbr_bit_rsp_t;

endpackage

[rtl/core/egbr_byte_queue.sv]
// ----------------------------------------------------------------------------
// egbr_byte_queue
// Ring buffer of stream bytes with registered read data.
// ----------------------------------------------------------------------------
module egbr_byte_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [7:0]              push_data,
    input  logic                    pop,
    output logic [7:0]              rd_data,
    output egbr_pkg::egbr_q_status_t status
);
    import egbr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [BYTE_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [BYTE_W-1:0] rd_data_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    assign rd_data      = rd_data_reg;
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

[rtl/core/egbr_bit_source.sv]
// ----------------------------------------------------------------------------
// egbr_bit_source
// Byte shift register that hands out stream bits MSB first, one per cycle
// except while fetching the next queue byte, which it does only when dry.
// ----------------------------------------------------------------------------
module egbr_bit_source (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     bit_take,
    output egbr_pkg::egbr_bit_rsp_t  bit_rsp,
    input  egbr_pkg::egbr_q_status_t q_status,
    output logic                     q_pop,
    input  logic [7:0]               q_rd_data
);
    import egbr_pkg::*;

    logic [BYTE_W-1:0]  shift_reg;
    logic [BYTE_W-1:0]  shift_next;
    logic [AVAIL_W-1:0] avail_reg;
    logic [AVAIL_W-1:0] avail_next;
    logic               pend_reg;
    logic               pend_next;
    logic               empty_acc;

    assign empty_acc = (avail_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            avail_reg <= avail_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    always_comb
    begin
        shift_next       = shift_reg;
        avail_next       = avail_reg;
        pend_next        = 1'b0;
        q_pop            = 1'b0;
        bit_rsp.valid    = 1'b0;
        bit_rsp.bit_val  = shift_reg[BYTE_W-1];
        bit_rsp.underrun = 1'b0;
        if (pend_reg)
        begin
            shift_next = q_rd_data;
            avail_next = AVAIL_W'(BYTE_W);
        end
        else if (bit_take)
        begin
            if (!empty_acc)
            begin
                bit_rsp.valid = 1'b1;
                shift_next    = {shift_reg[BYTE_W-2:0], 1'b0};
                avail_next    = avail_reg - AVAIL_W'(1);
            end
            else if (q_status.empty)
                bit_rsp.underrun = 1'b1;
            else
            begin
                q_pop     = 1'b1;
                pend_next = 1'b1;
            end
        end
    end

endmodule

[rtl/core/egbr_ctrl.sv]
// ----------------------------------------------------------------------------
// egbr_ctrl
// Request sequencer: pushes bytes, shifts in fixed fields and Exp-Golomb
// codes bit by bit, maps signed codes and keeps the sticky error flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module egbr_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic [1:0]               req_type,
    input  logic [7:0]               data_byte,
    input  logic [5:0]               field_width,
    output logic                     q_push,
    output logic [7:0]               q_push_data,
    input  egbr_pkg::egbr_q_status_t q_status,
    output logic                     bit_take,
    input  egbr_pkg::egbr_bit_rsp_t  bit_rsp,
    output logic                     res_valid,
    input  logic                     res_take,
    output logic [31:0]              res_value,
    output logic                     res_error
);
    import egbr_pkg::*;

    egbr_state_t        state_reg;
    egbr_state_t        state_next;
    logic [VALUE_W-1:0] val_reg;
    logic [VALUE_W-1:0] val_next;
    logic [NBITS_W-1:0] cnt_reg;
    logic [NBITS_W-1:0] cnt_next;
    logic [NBITS_W-1:0] zeros_reg;
    logic [NBITS_W-1:0] zeros_next;
    logic               sgn_reg;
    logic               sgn_next;
    logic               err_reg;
    logic               err_next;
    logic [VALUE_W-1:0] map_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            zeros_reg <= '0;
            sgn_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            zeros_reg <= zeros_next;
            sgn_reg   <= sgn_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    // signed mapping of k: odd -> (k+1)/2, even -> -(k/2)
    assign map_x = val_reg[0] ? {1'b0, val_reg[VALUE_W-1:1]}
                              : ~{1'b0, val_reg[VALUE_W-1:1]};

    always_comb
    begin
        state_next  = state_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        zeros_next  = zeros_reg;
        sgn_next    = sgn_reg;
        err_next    = err_reg;
        req_ready   = (state_reg == ST_IDLE);
        q_push      = 1'b0;
        q_push_data = data_byte;
        bit_take    = 1'b0;
        res_valid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (egbr_req_t'(req_type))
                        REQ_PUSH:
                        begin
                            if (q_status.full)
                                err_next = 1'b1;
                            else
                                q_push = 1'b1;
                        end
                        REQ_FIXED:
                        begin
                            val_next = '0;
                            if (err_reg || (field_width == '0))
                                state_next = ST_RESULT;
                            else if (field_width > NBITS_W'(MAX_FIELD))
                            begin
                                err_next   = 1'b1;
                                state_next = ST_RESULT;
                            end
                            else
                            begin
                                cnt_next   = field_width;
                                state_next = ST_FIXED;
                            end
                        end
                        default:
                        begin
                            val_next   = '0;
                            zeros_next = '0;
                            sgn_next   = (egbr_req_t'(req_type) == REQ_SE);
                            state_next = err_reg ? ST_RESULT : ST_PREFIX;
                        end
                    endcase
                end
            end
            ST_FIXED, ST_SUFFIX:
            begin
                bit_take = 1'b1;
                if (bit_rsp.underrun)
                begin
                    err_next   = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (bit_rsp.valid)
                begin
                    val_next = {val_reg[VALUE_W-2:0], bit_rsp.bit_val};
                    cnt_next = cnt_reg - NBITS_W'(1);
                    if (cnt_reg == NBITS_W'(1))
                        state_next = (state_reg == ST_FIXED) ? ST_RESULT : ST_DEC;
                end
            end
            ST_PREFIX:
            begin
                bit_take = 1'b1;
                if (bit_rsp.underrun)
                begin
                    err_next   = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (bit_rsp.valid)
                begin
                    if (bit_rsp.bit_val)
                    begin
                        val_next = VALUE_W'(1);
                        cnt_next = zeros_reg;
                        state_next = (zeros_reg == '0) ? ST_DEC : ST_SUFFIX;
                    end
                    else if (zeros_reg == NBITS_W'(MAX_ZEROS))
                    begin
                        err_next   = 1'b1;
                        state_next = ST_RESULT;
                    end
                    else
                        zeros_next = zeros_reg + NBITS_W'(1);
                end
            end
            ST_DEC:
            begin
                // leading one plus suffix, minus one; top bit drops off mod 2^32
                val_next   = val_reg - VALUE_W'(1);
                state_next = sgn_reg ? ST_MAP : ST_RESULT;
            end
            ST_MAP:
            begin
                val_next   = map_x + VALUE_W'(1);
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_take)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_value = err_reg ? '0 : val_reg;
    assign res_error = err_reg;

    `ASSERT_CHK(a_err_sticky, $past(err_reg) |-> err_reg, "error flag cleared")
    `ASSERT_NEVER(a_bit_idle, bit_rsp.valid && (state_reg == ST_IDLE),
        "bit consumed outside a read")
    `ASSERT_NEVER(a_cnt_zero,
        ((state_reg == ST_FIXED) || (state_reg == ST_SUFFIX)) && (cnt_reg == '0),
        "shift count empty while shifting")
    `ASSERT_NEVER(a_zeros_range, zeros_reg > NBITS_W'(MAX_ZEROS),
        "leading zero count out of range")

endmodule

[rtl/core/exp_golomb_bit_reader_core.sv]
// ----------------------------------------------------------------------------
// exp_golomb_bit_reader_core
// MSB-first bitstream reader with fixed-width and Exp-Golomb field decoding.
// ----------------------------------------------------------------------------
// Requests enter on s_axis: tuser carries the request type (push byte, fixed
// read, unsigned code, signed code), tdata the byte to push and the width of
// a fixed read. Pushes give no result; every read gives one result on
// m_axis: tdata the 32-bit field, tuser the sticky error flag.
// Bytes wait in a ring buffer of QUEUE_DEPTH entries and are pulled into an
// 8-bit shift register only when a read needs another bit; bits then leave
// one per cycle between byte fetches; the bit shift register sets the speed.
// A fixed read of n bits shifts them in one by one; a code shifts in its
// leading zeros, the one and the suffix, then takes a decrement step and,
// for a signed code, a mapping step. A read after an error returns zero.
// Requests are taken one at a time; a new request is taken while the last
// result still waits in the output register. A stalled receiver holds a
// finished read in its result step until the output register frees up.
// Reset empties the queue, drops buffered bits and clears the error flag.
// ----------------------------------------------------------------------------
module exp_golomb_bit_reader_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [13:8] field_width
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [0:0]  m_axis_tuser    // [0] error
);
    import egbr_pkg::*;

    egbr_q_status_t     q_status;
    egbr_bit_rsp_t      bit_rsp;
    logic               q_push;
    logic [BYTE_W-1:0]  q_push_data;
    logic               q_pop;
    logic [BYTE_W-1:0]  q_rd_data;
    logic               bit_take;
    logic               res_valid;
    logic               res_take;
    logic [VALUE_W-1:0] res_value;
    logic               res_error;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_error_reg;

    egbr_byte_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .rd_data   (q_rd_data),
        .status    (q_status)
    );

    egbr_bit_source u_bits (
        .clk       (clk),
        .rst_n     (rst_n),
        .bit_take  (bit_take),
        .bit_rsp   (bit_rsp),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .q_rd_data (q_rd_data)
    );

    egbr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req_type    (s_axis_tuser),
        .data_byte   (s_axis_tdata[7:0]),
        .field_width (s_axis_tdata[13:8]),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_status    (q_status),
        .bit_take    (bit_take),
        .bit_rsp     (bit_rsp),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res_value   (res_value),
        .res_error   (res_error)
    );

    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_value_reg <= res_value;
            out_error_reg <= res_error;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_value_reg;
    assign m_axis_tuser[0] = out_error_reg;

endmodule
